// ----- hw/rtl/scancode_to_char_keyboard_assert.svh -----
// Assertion helpers for the port-level checker file.
`ifndef SCANCODE_TO_CHAR_KEYBOARD_ASSERT_SVH
`define SCANCODE_TO_CHAR_KEYBOARD_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define SC2CH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, idle during reset.
`define SC2CH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/sc2ch_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sc2ch_pkg;

	// Scan set 1 framing
	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam int         REL_BIT     = 7;

	// Item actions
	localparam logic [1:0] ACT_SCAN   = 2'd0;
	localparam logic [1:0] ACT_LAYOUT = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	// Config register indexes
	localparam int         CFG_IW      = 3;
	localparam logic [2:0] CFG_LSHIFT  = 3'd0;
	localparam logic [2:0] CFG_RSHIFT  = 3'd1;
	localparam logic [2:0] CFG_CTRL    = 3'd2;
	localparam logic [2:0] CFG_ALT     = 3'd3;
	localparam logic [2:0] CFG_CAPS    = 3'd4;
	localparam logic [2:0] CFG_NUM     = 3'd5;
	localparam logic [2:0] CFG_SCROLL  = 3'd6;

	// Config reset values
	localparam logic [6:0] RST_LSHIFT = 7'd42;
	localparam logic [6:0] RST_RSHIFT = 7'd54;
	localparam logic [6:0] RST_CTRL   = 7'd29;
	localparam logic [6:0] RST_ALT    = 7'd56;
	localparam logic [6:0] RST_CAPS   = 7'd58;
	localparam logic [6:0] RST_NUM    = 7'd69;
	localparam logic [6:0] RST_SCROLL = 7'd70;

	// Output queue sizing
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = 3;
	localparam int OQ_CW    = 4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] scan_code;
		logic       layout_shifted;
		logic [6:0] layout_index;
		logic [7:0] layout_char;
	} in_item_t;

	typedef struct packed {
		logic shift_down;
		logic ctrl_down;
		logic alt_down;
		logic caps_on;
		logic num_on;
		logic scroll_on;
	} mods_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic       key_valid;
		logic [7:0] key_char;
		logic       has_data;
		logic       shift_down;
		logic       ctrl_down;
		logic       alt_down;
		logic       caps_on;
		logic       num_on;
		logic       scroll_on;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sc2ch_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input channel
interface sc2ch_in_if import sc2ch_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface sc2ch_out_if import sc2ch_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sc2ch_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, registered read.
module sc2ch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sc2ch_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Result queue with credit count; input side stalls only when every
// queue slot is spoken for by accepted transactions.
module sc2ch_outq import sc2ch_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  take,
	input  wire logic  push,
	input  wire res_t  push_data,
	output logic       room,
	sc2ch_out_if.source result
);

	res_t             q_mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q;
	logic [OQ_AW-1:0] rp_q;
	logic [OQ_CW-1:0] cnt_q;
	logic [OQ_CW-1:0] cred_q;
	logic             pop;

	assign pop          = result.valid && result.ready;
	assign result.valid = (cnt_q != '0);
	assign result.data  = q_mem[rp_q];
	assign room         = (cred_q < OQ_CW'(OQ_DEPTH));

	// Pointers, fill and credits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
			cred_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q  <= cnt_q + OQ_CW'(push) - OQ_CW'(pop);
			cred_q <= cred_q + OQ_CW'(take) - OQ_CW'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scancode_to_char_keyboard.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Scan set 1 keyboard decoder. Takes one transaction per clock while input
// ready is high: a scan byte, a layout table write or a character read, and
// returns one result per transaction, in order. The first stage tracks
// modifiers and the E0 prefix in flops and reads the layout RAM; the second
// applies caps/ctrl and does the character FIFO push or pop on its RAM; the
// third takes the popped byte and files the result into an eight-entry
// output queue. Input ready drops only when eight accepted transactions have
// not yet been taken at the result channel. Layout entries read as zero until
// written (per-entry valid flops, cleared at reset); the character FIFO holds
// FIFO_DEPTH-1 bytes and drops characters when full. The user writes config
// registers through cfg_we/cfg_idx/cfg_data only while idle; not enforced.
module scancode_to_char_keyboard import sc2ch_pkg::*; #(
	parameter int FIFO_DEPTH     = 256,
	parameter int LAYOUT_ENTRIES = 89
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_idx,
	input  wire logic [6:0]        cfg_data,
	sc2ch_in_if.sink               item,
	sc2ch_out_if.source            result
);

	localparam int LW = (LAYOUT_ENTRIES > 1) ? $clog2(LAYOUT_ENTRIES) : 1;
	localparam int PW = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CH_LA = 8'h61; // 'a'
	localparam logic [7:0] CH_LZ = 8'h7A; // 'z'
	localparam logic [7:0] CH_UA = 8'h41; // 'A'
	localparam logic [7:0] CH_UZ = 8'h5A; // 'Z'

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Config registers
	logic [6:0] lsh_q, rsh_q, ctl_q, alt_q, caps_q, num_q, scr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsh_q  <= RST_LSHIFT;
			rsh_q  <= RST_RSHIFT;
			ctl_q  <= RST_CTRL;
			alt_q  <= RST_ALT;
			caps_q <= RST_CAPS;
			num_q  <= RST_NUM;
			scr_q  <= RST_SCROLL;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_LSHIFT: lsh_q  <= cfg_data;
				CFG_RSHIFT: rsh_q  <= cfg_data;
				CFG_CTRL:   ctl_q  <= cfg_data;
				CFG_ALT:    alt_q  <= cfg_data;
				CFG_CAPS:   caps_q <= cfg_data;
				CFG_NUM:    num_q  <= cfg_data;
				CFG_SCROLL: scr_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// ---------------- stage 1: decode, modifiers, layout access ----------------
	logic                      room;
	logic                      take;
	in_item_t                  d;
	logic                      rel;
	logic [6:0]                code;
	logic                      in_rng;
	logic                      wr_rng;
	logic                      vld_hit;
	logic                      lkp;
	logic                      lay_we;
	logic                      lay_re;
	mods_t                     mods_q, mods_d;
	logic                      ext_q, ext_d;
	logic [LAYOUT_ENTRIES-1:0] vld_pl_q, vld_sh_q;
	logic [7:0]                lay_rdata;

	assign item.ready = room;
	assign take       = item.valid && item.ready;
	assign d          = item.data;
	assign rel        = d.scan_code[REL_BIT];
	assign code       = d.scan_code[6:0];
	assign in_rng     = ({1'b0, code} < 8'(LAYOUT_ENTRIES));
	assign wr_rng     = ({1'b0, d.layout_index} < 8'(LAYOUT_ENTRIES));
	assign vld_hit    = mods_q.shift_down ? vld_sh_q[code[LW-1:0]] : vld_pl_q[code[LW-1:0]];
	assign lay_we     = take && (d.action == ACT_LAYOUT) && wr_rng;
	assign lay_re     = lkp && in_rng;

	// Modifier and prefix tracking; first match wins
	always_comb begin
		mods_d = mods_q;
		ext_d  = ext_q;
		lkp    = 1'b0;
		if (take && (d.action == ACT_SCAN)) begin
			if (d.scan_code == PREFIX_BYTE) begin
				ext_d = 1'b1;
			end else if (ext_q) begin
				ext_d = 1'b0;
				if (code == ctl_q) begin
					mods_d.ctrl_down = !rel;
				end else if (code == alt_q) begin
					mods_d.alt_down = !rel;
				end
			end else if ((code == lsh_q) || (code == rsh_q)) begin
				mods_d.shift_down = !rel;
			end else if (code == ctl_q) begin
				mods_d.ctrl_down = !rel;
			end else if (code == alt_q) begin
				mods_d.alt_down = !rel;
			end else if (!rel) begin
				if (code == caps_q) begin
					mods_d.caps_on = !mods_q.caps_on;
				end else if (code == num_q) begin
					mods_d.num_on = !mods_q.num_on;
				end else if (code == scr_q) begin
					mods_d.scroll_on = !mods_q.scroll_on;
				end else begin
					lkp = 1'b1;
				end
			end
		end
	end

	// Layout tables: both in one RAM, shifted half on the top address bit
	sc2ch_ram #(
		.WIDTH (8),
		.DEPTH (2 ** (LW + 1))
	) u_layout_ram (
		.clk   (clk),
		.we    (lay_we),
		.waddr ({d.layout_shifted, d.layout_index[LW-1:0]}),
		.wdata (d.layout_char),
		.re    (lay_re),
		.raddr ({mods_q.shift_down, code[LW-1:0]}),
		.rdata (lay_rdata)
	);

	// Modifier state and layout valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q   <= '0;
			ext_q    <= 1'b0;
			vld_pl_q <= '0;
			vld_sh_q <= '0;
		end else begin
			mods_q <= mods_d;
			ext_q  <= ext_d;
			if (lay_we) begin
				if (d.layout_shifted) begin
					vld_sh_q[d.layout_index[LW-1:0]] <= 1'b1;
				end else begin
					vld_pl_q[d.layout_index[LW-1:0]] <= 1'b1;
				end
			end
		end
	end

	logic  v_s1;
	logic  vld_s1;
	logic  rd_s1;
	mods_t mods_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		vld_s1  <= lay_re && vld_hit;
		rd_s1   <= (d.action == ACT_READ);
		mods_s1 <= mods_d;
	end

	// ---------------- stage 2: character shaping, FIFO push/pop ----------------
	logic [7:0]    ch_raw, ch_cap, key;
	logic [PW-1:0] rp_q, wp_q, rp_d, wp_d;
	logic          push, pop;
	logic [7:0]    fifo_rdata;

	// Caps swaps case, then ctrl folds letters onto 1..26
	always_comb begin
		ch_raw = vld_s1 ? lay_rdata : 8'h00;
		ch_cap = (mods_s1.caps_on && is_letter(ch_raw)) ? (ch_raw ^ 8'h20) : ch_raw;
		key    = (mods_s1.ctrl_down && is_letter(ch_cap)) ? {3'b000, ch_cap[4:0]} : ch_cap;
	end

	assign push = v_s1 && (key != 8'h00) && (ptr_inc(wp_q) != rp_q);
	assign pop  = v_s1 && rd_s1 && (rp_q != wp_q);
	assign wp_d = push ? ptr_inc(wp_q) : wp_q;
	assign rp_d = pop ? ptr_inc(rp_q) : rp_q;

	sc2ch_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (push),
		.waddr (wp_q),
		.wdata (key),
		.re    (pop),
		.raddr (rp_q),
		.rdata (fifo_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
		end else begin
			rp_q <= rp_d;
			wp_q <= wp_d;
		end
	end

	logic       v_s2;
	logic       pop_s2;
	logic [7:0] key_s2;
	logic       has_s2;
	mods_t      mods_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pop_s2  <= pop;
		key_s2  <= v_s1 ? key : 8'h00;
		has_s2  <= (rp_d != wp_d);
		mods_s2 <= mods_s1;
	end

	// ---------------- stage 3: result assembly ----------------
	res_t res;

	always_comb begin
		res.read_char  = pop_s2 ? fifo_rdata : 8'h00;
		res.key_valid  = (key_s2 != 8'h00);
		res.key_char   = key_s2;
		res.has_data   = has_s2;
		res.shift_down = mods_s2.shift_down;
		res.ctrl_down  = mods_s2.ctrl_down;
		res.alt_down   = mods_s2.alt_down;
		res.caps_on    = mods_s2.caps_on;
		res.num_on     = mods_s2.num_on;
		res.scroll_on  = mods_s2.scroll_on;
	end

	sc2ch_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.push      (v_s2),
		.push_data (res),
		.room      (room),
		.result    (result)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/sc2ch_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "scancode_to_char_keyboard_assert.svh"

// Port-level checker for the keyboard decoder.
module sc2ch_chk import sc2ch_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire res_t out_data
);

	logic [OQ_CW-1:0] cnt_q;
	logic             in_take;
	logic             out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// Transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + OQ_CW'(in_take) - OQ_CW'(out_take);
		end
	end

	`SC2CH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
	`SC2CH_ASSERT_NOW(a_no_orphan, clk, arst_n, out_valid, cnt_q != '0, "result without an outstanding transaction")
	`SC2CH_ASSERT_NOW(a_no_stall, clk, arst_n, cnt_q < OQ_CW'(OQ_DEPTH), in_ready, "input stalled with queue room left")

endmodule

bind scancode_to_char_keyboard sc2ch_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

`default_nettype wire
